### rtl/core/grfc_pkg.sv
// Shared types and constants for the clamped Gaussian row filter.
package grfc_pkg;

   // Fixed field widths
   localparam int PIX_W      = 16;
   localparam int COEF_W     = 16;
   localparam int NUM_COEF   = 8;
   localparam int SPAN_W     = 3;
   localparam int ROW_W_W    = 13;
   localparam int COL_OUT_W  = 12;
   localparam int CSR_DATA_W = 64;

   // Arithmetic widths
   localparam int PAIR_W  = PIX_W + 1;
   localparam int PROD_W  = COEF_W + PAIR_W;
   localparam int QUAD_W  = PROD_W + 2;
   localparam int SUM_W   = PROD_W + 3;
   localparam int SCALE_W = SUM_W + 8;
   localparam int RND_POS = 24;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_SPAN       = 2'd0,
      CSR_ROW_WIDTH  = 2'd1,
      CSR_COEFF_LOW  = 2'd2,
      CSR_COEFF_HIGH = 2'd3
   } csr_index_type;

   // Tags that travel down the pipeline with each result
   typedef struct packed {
      logic [COL_OUT_W-1:0] column;
      logic                 row_end;
      logic                 burst_end;
   } meta_type;

endpackage

### rtl/core/gaussian_row_filter_clamped_top.sv
// Horizontal clamped Gaussian row filter: window, tap select, MAC pipeline, output register.
//
// Channel  Handshake             Payload
// req      req_valid/req_stall   req_pixel_value
// rsp      rsp_valid/rsp_stall   rsp_filtered_value, rsp_column, rsp_row_end, rsp_burst_end
// csr      csr_valid/csr_ready   csr_index, csr_data
//
// One pixel per cycle in steady state while rsp does not stall; each item passes the tap
// select, product, partial sum, full sum and output registers to rsp. The last pixel of a
// row gives min(span, column)+1 results, one per cycle while rsp does not stall, and the
// input stalls while the job counter drains. Reset is synchronous; it clears the job
// valid, the column counter, all stage valids and loads the register defaults. A stall on
// rsp backs up stage by stage, so bubbles in the pipeline are still filled from req.
module gaussian_row_filter_clamped_top
   import grfc_pkg::*;
#(
   parameter int MAX_SPAN  = 7,
   parameter int MAX_WIDTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // input pixels
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel_value,
   // filtered pixels
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_filtered_value,
   output logic [COL_OUT_W-1:0]  rsp_column,
   output logic                  rsp_row_end,
   output logic                  rsp_burst_end,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int TAPS   = (MAX_SPAN < NUM_COEF - 1) ? MAX_SPAN + 1 : NUM_COEF;
   localparam int WIN    = 2 * TAPS - 1;
   localparam int WIN_IW = $clog2(WIN);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam logic [SPAN_W-1:0] SPAN_CAP = SPAN_W'(TAPS - 1);

   // configuration registers
   logic [SPAN_W-1:0]     span_ff;
   logic [ROW_W_W-1:0]    row_width_ff;
   logic [CSR_DATA_W-1:0] coeff_low_ff;
   logic [CSR_DATA_W-1:0] coeff_high_ff;
   logic [2*CSR_DATA_W-1:0] coef_all;

   // window and row state
   logic [PIX_W-1:0] win_ff [WIN];
   logic [PIX_W-1:0] first_ff;
   logic [COL_W-1:0] col_ff;

   // pending result job
   logic              job_valid_ff;
   logic              job_flush_ff;
   logic [SPAN_W-1:0] job_d0_ff;
   logic [COL_W-1:0]  job_col_ff;

   // control
   logic              req_accept;
   logic              issue;
   logic              last_job;
   logic              ends;
   logic              cur_ge_span;
   logic [SPAN_W-1:0] eff_span;
   logic [SPAN_W-1:0] d0_in;
   logic [ROW_W_W-1:0] width_eff;
   logic [ROW_W_W-1:0] width_last;
   logic              take1, take2, take3, take4, take5;

   // pipeline stages
   logic              v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   meta_type          meta1_ff, meta2_ff, meta3_ff, meta4_ff, rsp_meta_ff;
   meta_type          meta1_in;
   logic [PAIR_W-1:0] pair_in  [NUM_COEF];
   logic [PAIR_W-1:0] pair_ff  [NUM_COEF];
   logic [PROD_W-1:0] prod_ff  [NUM_COEF];
   logic [QUAD_W-1:0] quad_in  [2];
   logic [QUAD_W-1:0] quad_ff  [2];
   logic [SUM_W-1:0]  sum_ff;
   logic [SCALE_W-1:0] scaled;
   logic [PIX_W-1:0]  value_in;
   logic [PIX_W-1:0]  rsp_value_ff;

   // ---------------------------------------------------------------
   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff       <= '0;
         row_width_ff  <= ROW_W_W'(4096);
         coeff_low_ff  <= CSR_DATA_W'(65535);
         coeff_high_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SPAN:       span_ff       <= csr_data[SPAN_W-1:0];
            CSR_ROW_WIDTH:  row_width_ff  <= csr_data[ROW_W_W-1:0];
            CSR_COEFF_LOW:  coeff_low_ff  <= csr_data;
            CSR_COEFF_HIGH: coeff_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign coef_all = {coeff_high_ff, coeff_low_ff};

   // effective span and row width
   assign eff_span = (span_ff > SPAN_CAP) ? SPAN_CAP : span_ff;

   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = ROW_W_W'(1);
      end else if (int'(row_width_ff) > MAX_WIDTH) begin
         width_eff = ROW_W_W'(MAX_WIDTH);
      end else begin
         width_eff = row_width_ff;
      end
      width_last = width_eff - ROW_W_W'(1);
   end

   // ---------------------------------------------------------------
   // handshake chain: a stage loads when it is empty or its successor loads
   assign take5 = !rsp_valid_ff || !rsp_stall;
   assign take4 = !v4_ff || take5;
   assign take3 = !v3_ff || take4;
   assign take2 = !v2_ff || take3;
   assign take1 = !v1_ff || take2;

   assign last_job   = !job_flush_ff || (job_d0_ff == '0);
   assign issue      = job_valid_ff && take1;
   assign req_stall  = job_valid_ff && !(last_job && take1);
   assign req_accept = req_valid && !req_stall;

   // new job from the incoming pixel
   assign ends        = int'(col_ff) >= int'(width_last);
   assign cur_ge_span = int'(col_ff) >= int'(eff_span);
   assign d0_in       = (ends && !cur_ge_span) ? col_ff[SPAN_W-1:0] : eff_span;

   // window shift and row state
   always_ff @(posedge clock) begin
      if (req_accept) begin
         win_ff[0] <= req_pixel_value;
         for (int i = 1; i < WIN; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
         if (col_ff == '0) begin
            first_ff <= req_pixel_value;
         end
      end
   end

   // job sequencer: one result per issue, counting down the center distance on a flush
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         col_ff       <= '0;
      end else if (req_accept) begin
         job_valid_ff <= ends || cur_ge_span;
         col_ff       <= ends ? '0 : col_ff + COL_W'(1);
      end else if (issue && last_job) begin
         job_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         job_flush_ff <= ends;
         job_d0_ff    <= d0_in;
         job_col_ff   <= col_ff - COL_W'(d0_in);
      end else if (issue && !last_job) begin
         job_d0_ff    <= job_d0_ff - SPAN_W'(1);
         job_col_ff   <= job_col_ff + COL_W'(1);
      end
   end

   // ---------------------------------------------------------------
   // stage 1: tap select with left and right clamp, pair sums
   always_comb begin
      int li;
      int ri;
      logic [PIX_W-1:0] lpx;
      logic [PIX_W-1:0] rpx;
      li = int'(job_d0_ff);
      pair_in[0] = {1'b0, win_ff[li[WIN_IW-1:0]]};
      for (int k = 1; k < NUM_COEF; k++) begin
         li = int'(job_d0_ff) + k;
         ri = int'(job_d0_ff) - k;
         // left of column 0 reads the row's first pixel
         if (k > int'(job_col_ff)) begin
            lpx = first_ff;
         end else if (li < WIN) begin
            lpx = win_ff[li[WIN_IW-1:0]];
         end else begin
            lpx = '0;
         end
         // right of the newest pixel reads the newest pixel
         if (ri < 0) begin
            rpx = win_ff[0];
         end else begin
            rpx = win_ff[ri[WIN_IW-1:0]];
         end
         if (k <= int'(eff_span)) begin
            pair_in[k] = {1'b0, lpx} + {1'b0, rpx};
         end else begin
            pair_in[k] = '0;
         end
      end
   end

   assign meta1_in.column    = COL_OUT_W'(job_col_ff);
   assign meta1_in.row_end   = job_flush_ff && (job_d0_ff == '0);
   assign meta1_in.burst_end = last_job;

   always_ff @(posedge clock) begin
      if (take1) begin
         pair_ff  <= pair_in;
         meta1_ff <= meta1_in;
      end
   end

   // stage 2: coefficient products
   always_ff @(posedge clock) begin
      if (take2) begin
         for (int k = 0; k < NUM_COEF; k++) begin
            prod_ff[k] <= PROD_W'(coef_all[k*COEF_W +: COEF_W]) * PROD_W'(pair_ff[k]);
         end
         meta2_ff <= meta1_ff;
      end
   end

   // stage 3: two partial sums of four products
   always_comb begin
      for (int h = 0; h < 2; h++) begin
         quad_in[h] = QUAD_W'(prod_ff[4*h])   + QUAD_W'(prod_ff[4*h+1]) +
                      QUAD_W'(prod_ff[4*h+2]) + QUAD_W'(prod_ff[4*h+3]);
      end
   end

   always_ff @(posedge clock) begin
      if (take3) begin
         quad_ff  <= quad_in;
         meta3_ff <= meta2_ff;
      end
   end

   // stage 4: full sum
   always_ff @(posedge clock) begin
      if (take4) begin
         sum_ff   <= SUM_W'(quad_ff[0]) + SUM_W'(quad_ff[1]);
         meta4_ff <= meta3_ff;
      end
   end

   // stage 5: times 255, round to 8.8, saturate
   assign scaled   = {sum_ff, 8'b0} - SCALE_W'(sum_ff) + SCALE_W'(1 << (RND_POS - 1));
   assign value_in = (|scaled[SCALE_W-1:RND_POS+PIX_W]) ? '1 :
                     scaled[RND_POS+PIX_W-1:RND_POS];

   always_ff @(posedge clock) begin
      if (take5) begin
         rsp_value_ff <= value_in;
         rsp_meta_ff  <= meta4_ff;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take1) v1_ff        <= issue;
         if (take2) v2_ff        <= v1_ff;
         if (take3) v3_ff        <= v2_ff;
         if (take4) v4_ff        <= v3_ff;
         if (take5) rsp_valid_ff <= v4_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_column         = rsp_meta_ff.column;
   assign rsp_row_end        = rsp_meta_ff.row_end;
   assign rsp_burst_end      = rsp_meta_ff.burst_end;

   // ---------------------------------------------------------------
   // checks

   // a flush job that is not its last must hold off new pixels
   assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !last_job |-> req_stall)
      else $error("pixel accepted during row flush");

   // a row-ending pixel always leaves a flush job behind
   assert property (@(posedge clock) disable iff (reset)
      req_accept && ends |=> job_valid_ff && job_flush_ff)
      else $error("row end did not start a flush");

   // each flush issue moves one column right
   assert property (@(posedge clock) disable iff (reset)
      issue && !last_job |=> job_valid_ff && (job_col_ff == $past(job_col_ff) + COL_W'(1)))
      else $error("flush column did not advance");

   // the row end is always the last result of its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_meta_ff.row_end |-> rsp_meta_ff.burst_end)
      else $error("row end without burst end");

endmodule

### tb/sv/gaussian_row_filter_clamped_top_tb.sv
// Self-checking testbench for the clamped Gaussian row filter: driver, predictor, monitor.
`timescale 1ns / 1ps

module gaussian_row_filter_clamped_top_tb
   import grfc_pkg::*;
();

   localparam int SPAN_LIMIT  = 7;
   localparam int WIDTH_LIMIT = 4096;
   localparam int WIN_DEPTH   = 2 * SPAN_LIMIT + 1;
   localparam int SETTLE      = 16;      // cycles past the last result before idle
   localparam int HOLD_CYCLES = 200;     // long receiver hold-off
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 13;

   // Stimulus operations queued for the driver
   typedef enum {
      OP_PIXEL, OP_WRITE, OP_DRAIN, OP_HOLD, OP_STEADY_ON, OP_STEADY_OFF
   } stim_kind_type;

   typedef struct {
      stim_kind_type       kind;
      csr_index_type       index;
      logic [63:0]         data;
   } stim_op_type;

   typedef struct packed {
      logic [PIX_W-1:0]     value;
      logic [COL_OUT_W-1:0] column;
      logic                 row_end;
      logic                 burst_end;
   } blurred_pixel_type;

   // DUT signals; the inputs are known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_filtered_value;
   logic [COL_OUT_W-1:0]  rsp_column;
   logic                  rsp_row_end;
   logic                  rsp_burst_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_SPAN;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Predictor state and register copies
   logic [SPAN_W-1:0]     span_q;
   logic [ROW_W_W-1:0]    width_q;
   logic [63:0]           coef_lo;
   logic [63:0]           coef_hi;
   logic [PIX_W-1:0]      row_pixels [WIN_DEPTH];
   int                    col_in;
   logic [PIX_W-1:0]      row_first;

   stim_op_type           stim_ops [$];
   blurred_pixel_type     blurred_due [$];

   // Handshake between driver and monitor for pressure phases
   logic                  steady = 1'b0;
   int                    hold_requests = 0;
   int                    hold_served;
   int                    hold_left;
   int                    quiet_cycles;
   int                    fail_count = 0;
   int                    cycle_count = 0;

   gaussian_row_filter_clamped_top #(
      .MAX_SPAN (SPAN_LIMIT),
      .MAX_WIDTH(WIDTH_LIMIT)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_value   (req_pixel_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered_value(rsp_filtered_value),
      .rsp_column        (rsp_column),
      .rsp_row_end       (rsp_row_end),
      .rsp_burst_end     (rsp_burst_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   task automatic clear_filter_state();
      span_q    = '0;
      width_q   = 13'd4096;
      coef_lo   = 64'd65535;
      coef_hi   = '0;
      col_in    = 0;
      row_first = '0;
      for (int d = 0; d < WIN_DEPTH; d++) row_pixels[d] = '0;
   endtask

   task automatic apply_write(input csr_index_type idx, input logic [63:0] data);
      unique case (idx)
         CSR_SPAN:       span_q  = data[SPAN_W-1:0];
         CSR_ROW_WIDTH:  width_q = data[ROW_W_W-1:0];
         CSR_COEFF_LOW:  coef_lo = data;
         CSR_COEFF_HIGH: coef_hi = data;
         default: ;
      endcase
   endtask

   function automatic logic [63:0] coef_of(int k);
      if (k < 4) return (coef_lo >> (16 * k)) & 64'hFFFF;
      return (coef_hi >> (16 * (k - 4))) & 64'hFFFF;
   endfunction

   // Row pixel at column p with clamping at both edges; cur is the newest column
   function automatic logic [63:0] tap(int p, int cur);
      int d;
      if (p < 0) return {48'd0, row_first};
      if (p > cur) p = cur;
      d = cur - p;
      if (d >= WIN_DEPTH) return 64'd0;
      return {48'd0, row_pixels[d]};
   endfunction

   function automatic logic [PIX_W-1:0] blur_at(int c, int cur, int s);
      logic [63:0] acc;
      logic [63:0] scaled;
      acc = coef_of(0) * tap(c, cur);
      for (int k = 1; k <= s; k++)
         acc += coef_of(k) * (tap(c - k, cur) + tap(c + k, cur));
      // x255, round to 8.8, saturate
      scaled = (acc * 64'd255 + (64'd1 << 23)) >> 24;
      return (scaled > 64'hFFFF) ? 16'hFFFF : scaled[PIX_W-1:0];
   endfunction

   // Shift one pixel into the row and queue the blurred pixels it releases
   task automatic advance_row(input logic [PIX_W-1:0] px);
      int                s;
      int                w;
      int                cur;
      int                first;
      blurred_pixel_type r;
      s = (span_q > SPAN_LIMIT) ? SPAN_LIMIT : span_q;
      w = width_q;
      if (w < 1) w = 1;
      if (w > WIDTH_LIMIT) w = WIDTH_LIMIT;
      cur = col_in;
      for (int d = WIN_DEPTH - 1; d > 0; d--) row_pixels[d] = row_pixels[d - 1];
      row_pixels[0] = px;
      if (cur == 0) row_first = px;
      if (cur >= w - 1) begin
         // row end flushes the remaining columns
         first = (cur - s < 0) ? 0 : cur - s;
         for (int c = first; c <= cur; c++) begin
            r.value     = blur_at(c, cur, s);
            r.column    = c[COL_OUT_W-1:0];
            r.row_end   = (c == cur);
            r.burst_end = (c == cur);
            blurred_due.push_back(r);
         end
         col_in = 0;
      end else begin
         if (cur >= s) begin
            r.value     = blur_at(cur - s, cur, s);
            r.column    = COL_OUT_W'(cur - s);
            r.row_end   = 1'b0;
            r.burst_end = 1'b1;
            blurred_due.push_back(r);
         end
         col_in++;
      end
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   task automatic queue_op(input stim_kind_type kind);
      stim_op_type op;
      op.kind  = kind;
      op.index = CSR_SPAN;
      op.data  = '0;
      stim_ops.push_back(op);
   endtask

   task automatic queue_pixel(input logic [PIX_W-1:0] px);
      stim_op_type op;
      op.kind  = OP_PIXEL;
      op.index = CSR_SPAN;
      op.data  = {48'd0, px};
      stim_ops.push_back(op);
   endtask

   // Wait for idle, then write every register
   task automatic queue_settings(input int s, input int w, input logic [63:0] lo,
                                 input logic [63:0] hi);
      stim_op_type op;
      queue_op(OP_DRAIN);
      op.kind = OP_WRITE;
      op.index = CSR_SPAN;       op.data = 64'(s); stim_ops.push_back(op);
      op.index = CSR_ROW_WIDTH;  op.data = 64'(w); stim_ops.push_back(op);
      op.index = CSR_COEFF_LOW;  op.data = lo;     stim_ops.push_back(op);
      op.index = CSR_COEFF_HIGH; op.data = hi;     stim_ops.push_back(op);
   endtask

   // Coefficients: normalized so the active taps sum to at most one, or fully random
   task automatic rand_coeffs(input int s, input bit full, output logic [63:0] lo,
                              output logic [63:0] hi);
      logic [15:0] c [8];
      int          lim;
      lim = 65536 / (2 * s + 1);
      for (int k = 0; k < 8; k++) begin
         if (full || k > s) c[k] = 16'($urandom_range(65535));
         else c[k] = 16'($urandom_range(lim - 1));
      end
      lo = {c[3], c[2], c[1], c[0]};
      hi = {c[7], c[6], c[5], c[4]};
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(15))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive
      stim_op_type head;
      logic        next_req;
      logic        next_csr;
      if (reset) begin
         clear_filter_state();
         req_valid    <= 1'b0;
         csr_valid    <= 1'b0;
         steady       <= 1'b0;
         quiet_cycles = 0;
      end else begin
         if (req_valid && !req_stall) advance_row(req_pixel_value);
         if (csr_valid && csr_ready) apply_write(csr_index, csr_data);
         // idle means nothing owed and nothing offered
         if (blurred_due.size() == 0 && !req_valid) quiet_cycles++;
         else quiet_cycles = 0;
         next_req = req_valid && req_stall;
         next_csr = csr_valid && !csr_ready;
         if (!next_req && !next_csr && stim_ops.size() > 0) begin
            head = stim_ops[0];
            case (head.kind)
               OP_PIXEL: begin
                  if (steady || $urandom_range(99) >= IDLE_PCT) begin
                     req_pixel_value <= head.data[PIX_W-1:0];
                     next_req = 1'b1;
                     void'(stim_ops.pop_front());
                  end
               end
               OP_WRITE: begin
                  csr_index <= head.index;
                  csr_data  <= head.data;
                  next_csr  = 1'b1;
                  void'(stim_ops.pop_front());
               end
               OP_DRAIN: begin
                  if (quiet_cycles >= SETTLE) void'(stim_ops.pop_front());
               end
               OP_HOLD: begin
                  hold_requests <= hold_requests + 1;
                  void'(stim_ops.pop_front());
               end
               OP_STEADY_ON: begin
                  steady <= 1'b1;
                  void'(stim_ops.pop_front());
               end
               OP_STEADY_OFF: begin
                  steady <= 1'b0;
                  void'(stim_ops.pop_front());
               end
               default: void'(stim_ops.pop_front());
            endcase
         end
         req_valid <= next_req;
         csr_valid <= next_csr;
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      blurred_pixel_type want;
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_left   = 0;
         hold_served = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (blurred_due.size() == 0) begin
               $error("unexpected item: column %0d value %0d", rsp_column,
                      rsp_filtered_value);
               fail_count++;
            end else begin
               want = blurred_due.pop_front();
               check_field("filtered_value", want.value, rsp_filtered_value);
               check_field("column", 16'(want.column), 16'(rsp_column));
               check_field("row_end", 16'(want.row_end), 16'(rsp_row_end));
               check_field("burst_end", 16'(want.burst_end), 16'(rsp_burst_end));
            end
         end
         // long hold-off on request, otherwise random stalls outside steady phases
         if (hold_served != hold_requests) begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_requests;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : sequencer
      logic [63:0] lo;
      logic [63:0] hi;
      int          s;
      int          w;

      // Reset defaults: span 0, unit center tap
      queue_pixel(16'hFFFF);
      queue_pixel(16'h0000);
      queue_pixel(16'h8001);

      // Widest span, all coefficients full scale: saturation and an eight-item flush
      queue_settings(7, 9, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      for (int i = 0; i < 9; i++) queue_pixel((i == 4) ? 16'h0000 : 16'hFFFF);

      // Zero width acts as one: every pixel ends its row
      queue_settings(2, 0, 64'h0000_2000_4000_4000, 64'h0);
      queue_pixel(16'hFFFF);
      queue_pixel(16'h1234);

      // Over-range width, then span change mid-row, then width cut below the column
      queue_settings(3, 8191, 64'h1000_2000_3000_4000, 64'h0);
      for (int i = 0; i < 6; i++) queue_pixel(rand_pixel());
      queue_settings(1, 8191, 64'h1000_2000_3000_4000, 64'h0);
      for (int i = 0; i < 4; i++) queue_pixel(rand_pixel());
      queue_settings(1, 2, 64'h1000_2000_3000_4000, 64'h0);
      queue_pixel(rand_pixel());

      // Random phases: rows of random content under several settings
      for (int ph = 0; ph < 6; ph++) begin
         s = (ph == 0) ? 0 : (ph == 5) ? 7 : $urandom_range(7);
         case (ph)
            3:       w = 0;
            4:       w = 4096 + $urandom_range(1, 4095);
            default: w = $urandom_range(1, 20);
         endcase
         rand_coeffs(s, ph == 2, lo, hi);
         queue_settings(s, w, lo, hi);
         for (int i = 0; i < 8; i++) begin
            if ($urandom_range(9) == 0) queue_op(OP_DRAIN);
            queue_pixel(rand_pixel());
         end
      end

      // Back-pressure: receiver holds off while the sender keeps offering
      rand_coeffs(3, 1'b0, lo, hi);
      queue_settings(3, 10, lo, hi);
      queue_op(OP_HOLD);
      queue_op(OP_STEADY_ON);
      for (int i = 0; i < 30; i++) queue_pixel(rand_pixel());
      queue_op(OP_STEADY_OFF);

      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (!(stim_ops.size() == 0 && !req_valid && !csr_valid && blurred_due.size() == 0))
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
